FILE: hw/rtl/ordered_list_insert_remove_macros.svh
// Assertion macros used by the checker of the ordered list block.
// Each macro expands to one labeled concurrent assertion clocked on i_clk.
`ifndef ORDERED_LIST_INSERT_REMOVE_MACROS_SVH
`define ORDERED_LIST_INSERT_REMOVE_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define OLIR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ordered list check failed");

// Check a consequent in the cycle after its antecedent.
`define OLIR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ordered list check failed");

`endif

FILE: hw/rtl/olir_pkg.sv
// Types and constants of the ordered list block.
// Used by the interfaces, controller, datapath, top level and checker.
package olir_pkg;

    localparam int W_ACTION    = 2;
    localparam int W_VALUE     = 32;
    localparam int W_STATUS    = 2;
    localparam int W_ENTRY_CNT = 5;

    typedef enum logic [W_ACTION-1:0] {
        ACT_FRONT  = 2'd0,
        ACT_BACK   = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    typedef enum logic [W_STATUS-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    // Datapath operations applied to the cell chain
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_FRONT  = 3'd1,
        OP_BACK   = 3'd2,
        OP_MATCH  = 3'd3,
        OP_REMOVE = 3'd4,
        OP_ROTATE = 3'd5
    } t_op;

    typedef struct packed {
        t_op     op;
        logic    rd_clear;
        logic    out_load;
        t_status out_status;
        logic    out_entry;
        logic    out_last;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic hit_any;
        logic rd_last;
        logic out_free;
    } t_sts;

endpackage

FILE: hw/rtl/olir_if.sv
// Valid/ready channel interfaces of the ordered list block.
// Depends on olir_pkg for the field widths.
interface olir_in_if import olir_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic [W_ACTION-1:0]         action;
    logic signed [W_VALUE-1:0]   value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface olir_out_if import olir_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic [W_STATUS-1:0]         status;
    logic signed [W_VALUE-1:0]   entry_value;
    logic [W_ENTRY_CNT-1:0]      entry_count;
    logic                        last;

    modport source (output valid, output status, output entry_value, output entry_count,
                    output last, input ready);
    modport sink   (input valid, input status, input entry_value, input entry_count,
                    input last, output ready);
endinterface

FILE: hw/rtl/olir_datapath.sv
// Cell chain, entry count, match vector and output register of the ordered list.
// Depends on olir_pkg; driven by olir_ctrl through t_cmd, reports through t_sts.
module olir_datapath import olir_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cmd                        i_cmd,
    input  logic signed [W_VALUE-1:0]   i_value,
    output t_sts                        o_sts,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [W_STATUS-1:0]         o_status,
    output logic signed [W_VALUE-1:0]   o_entry_value,
    output logic [W_ENTRY_CNT-1:0]      o_entry_count,
    output logic                        o_last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic signed [W_VALUE-1:0]  r_cell [CAPACITY];
    logic signed [W_VALUE-1:0]  n_cell [CAPACITY];
    logic [CAPACITY-1:0]        r_hit, n_hit;
    logic [CAPACITY-1:0]        w_first, w_tail;
    logic [CW-1:0]              r_count, n_count;
    logic [CW-1:0]              r_rd_idx, n_rd_idx;
    logic [CW-1:0]              w_count_dec;
    logic [IW-1:0]              w_back_idx, w_rot_idx;

    logic                       r_out_valid;
    t_status                    r_status;
    logic signed [W_VALUE-1:0]  r_entry_value;
    logic [W_ENTRY_CNT-1:0]     r_entry_count;
    logic                       r_last;

    assign w_count_dec = r_count - CW'(1);
    assign w_back_idx  = r_count[IW-1:0];
    assign w_rot_idx   = w_count_dec[IW-1:0];

    // Isolate the first match and mark every cell from it to the end
    assign w_first = r_hit & (~r_hit + CAPACITY'(1));
    assign w_tail  = ~(w_first - CAPACITY'(1));

    // Compare all valid cells against the search value
    always_comb begin
        n_hit = r_hit;
        if (i_cmd.op == OP_MATCH) begin
            for (int i = 0; i < CAPACITY; i++) begin
                n_hit[i] = (r_cell[i] == i_value) && (CW'(i) < r_count);
            end
        end
    end

    // Next contents of the cell chain and the count
    always_comb begin
        n_cell  = r_cell;
        n_count = r_count;
        case (i_cmd.op)
            OP_FRONT: begin
                n_cell[0] = i_value;
                for (int i = 1; i < CAPACITY; i++) begin
                    n_cell[i] = r_cell[i-1];
                end
                n_count = r_count + CW'(1);
            end
            OP_BACK: begin
                n_cell[w_back_idx] = i_value;
                n_count = r_count + CW'(1);
            end
            OP_REMOVE: begin
                for (int i = 0; i < CAPACITY - 1; i++) begin
                    if (w_tail[i]) begin
                        n_cell[i] = r_cell[i+1];
                    end
                end
                n_count = w_count_dec;
            end
            OP_ROTATE: begin
                // Front entry leaves and re-enters behind the last valid cell
                for (int i = 0; i < CAPACITY - 1; i++) begin
                    n_cell[i] = r_cell[i+1];
                end
                n_cell[w_rot_idx] = r_cell[0];
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Clear or advance the read-out position
    always_comb begin
        n_rd_idx = r_rd_idx;
        if (i_cmd.rd_clear) begin
            n_rd_idx = '0;
        end else if (i_cmd.op == OP_ROTATE) begin
            n_rd_idx = r_rd_idx + CW'(1);
        end
    end

    // Cells and match vector hold payload only
    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
        r_hit  <= n_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rd_idx <= '0;
        end else begin
            r_count  <= n_count;
            r_rd_idx <= n_rd_idx;
        end
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_status      <= i_cmd.out_status;
            r_entry_value <= i_cmd.out_entry ? r_cell[0] : '0;
            r_entry_count <= W_ENTRY_CNT'(n_count);
            r_last        <= i_cmd.out_last;
        end
    end

    assign o_sts.empty    = (r_count == '0);
    assign o_sts.full     = (r_count >= CW'(CAPACITY));
    assign o_sts.hit_any  = |r_hit;
    assign o_sts.rd_last  = ((r_rd_idx + CW'(1)) == r_count);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_entry_value = r_entry_value;
    assign o_entry_count = r_entry_count;
    assign o_last        = r_last;

endmodule

FILE: hw/rtl/olir_ctrl.sv
// Controller state machine of the ordered list: decodes actions into datapath commands.
// Depends on olir_pkg; talks to olir_datapath only through t_cmd and t_sts.
module olir_ctrl import olir_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [W_ACTION-1:0]   i_action,
    output logic                  o_ready,
    input  t_sts                  i_sts,
    output t_cmd                  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CLOSE = 3'b010,
        S_READ  = 3'b100
    } t_state;

    t_state  r_state, n_state;
    t_action w_action;

    assign w_action = t_action'(i_action);

    // Decode the current state into commands and the next state
    always_comb begin
        n_state          = r_state;
        o_ready          = 1'b0;
        o_cmd.op         = OP_NONE;
        o_cmd.rd_clear   = 1'b0;
        o_cmd.out_load   = 1'b0;
        o_cmd.out_status = ST_OK;
        o_cmd.out_entry  = 1'b0;
        o_cmd.out_last   = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_ready = i_sts.out_free;
                if (i_valid && i_sts.out_free) begin
                    case (w_action)
                        ACT_FRONT, ACT_BACK: begin
                            o_cmd.out_load = 1'b1;
                            if (i_sts.full) begin
                                o_cmd.out_status = ST_FULL;
                            end else begin
                                o_cmd.op = (w_action == ACT_FRONT) ? OP_FRONT : OP_BACK;
                            end
                        end
                        ACT_REMOVE: begin
                            if (i_sts.empty) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = ST_EMPTY;
                            end else begin
                                o_cmd.op = OP_MATCH;
                                n_state  = S_CLOSE;
                            end
                        end
                        ACT_READ: begin
                            if (i_sts.empty) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = ST_EMPTY;
                            end else begin
                                o_cmd.rd_clear = 1'b1;
                                n_state        = S_READ;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CLOSE: begin
                // Close the gap at the first match, or report no match
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_sts.hit_any) begin
                        o_cmd.op = OP_REMOVE;
                    end else begin
                        o_cmd.out_status = ST_NOTFOUND;
                    end
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                // Emit the front entry and rotate the chain, one entry per cycle while the output is free
                if (i_sts.out_free) begin
                    o_cmd.op        = OP_ROTATE;
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_entry = 1'b1;
                    o_cmd.out_last  = i_sts.rd_last;
                    if (i_sts.rd_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hw/rtl/ordered_list_insert_remove.sv
// Ordered list of signed 32-bit values, up to CAPACITY entries, with front/back insert,
// remove of the first match and full read out. Each item is one action; every item yields
// one result, except a read out of a non-empty list, which yields one result per entry with
// last set on the final one. Items are handled one at a time: an insert writes the chain
// directly; a remove does a parallel compare of all cells, then the shift that closes the
// gap; a read out clears the read position, then emits one entry per cycle while the output
// register is free, paced by rotating the cell chain through its front cell. A registered
// output stage holds each result; stalls there hold back the next step. No clearing is
// needed after reset. Depends on olir_pkg, olir_if, olir_ctrl and olir_datapath.
module ordered_list_insert_remove import olir_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    olir_in_if.sink     i_req,
    olir_out_if.source  o_rsp
);

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequence each action
    olir_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_req.valid),
        .i_action (i_req.action),
        .o_ready  (i_req.ready),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd)
    );

    // Hold the list and the result register
    olir_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_value       (i_req.value),
        .o_sts         (w_sts),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_status      (o_rsp.status),
        .o_entry_value (o_rsp.entry_value),
        .o_entry_count (o_rsp.entry_count),
        .o_last        (o_rsp.last)
    );

endmodule

FILE: hw/rtl/olir_checker.sv
// Port-level checks of the ordered list block, bound to its top level.
// Depends on olir_pkg and ordered_list_insert_remove_macros.svh.
`include "ordered_list_insert_remove_macros.svh"

module olir_checker import olir_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [W_STATUS-1:0]        i_status,
    input logic signed [W_VALUE-1:0]  i_entry_value,
    input logic [W_ENTRY_CNT-1:0]     i_entry_count,
    input logic                       i_last
);

    // A stalled result stays and keeps its entry value and status
    `OLIR_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_entry_value) && $stable(i_status))

    // A dropped insert only happens on a full list and ends its item
    `OLIR_ASSERT_NOW(a_full_count, i_out_valid && i_status == ST_FULL, i_entry_count == W_ENTRY_CNT'(CAPACITY) && i_last)

    // Empty list reports carry no entry and a zero count
    `OLIR_ASSERT_NOW(a_empty_zero, i_out_valid && i_status == ST_EMPTY, i_entry_count == '0 && i_entry_value == '0 && i_last)

    // A failed search leaves a non-empty list and carries no entry
    `OLIR_ASSERT_NOW(a_notfound, i_out_valid && i_status == ST_NOTFOUND, i_entry_count != '0 && i_entry_value == '0 && i_last)

endmodule

bind ordered_list_insert_remove olir_checker #(
    .CAPACITY (CAPACITY)
) u_olir_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_status      (o_rsp.status),
    .i_entry_value (o_rsp.entry_value),
    .i_entry_count (o_rsp.entry_count),
    .i_last        (o_rsp.last)
);
